// ===== hw/rtl/psu_pkg.sv =====
// ----------------------------------------------------------------------------
// psu_pkg: shared definitions for the PNG scanline unfilter
// Default sizes, register indexes, colour modes, filter types, status codes
// and the word that the input stage hands to the unfilter stage.
// ----------------------------------------------------------------------------
package psu_pkg;

  localparam int MAX_WIDTH_DEF     = 8192;
  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int MAX_HEIGHT        = 8192;

  // Configuration register indexes (byte address is four times the index)
  localparam logic [1:0] REG_WIDTH   = 2'd0;
  localparam logic [1:0] REG_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_MODE    = 2'd2;
  localparam logic [1:0] REG_PALSIZE = 2'd3;

  localparam logic [1:0] MODE_RGB  = 2'd0;
  localparam logic [1:0] MODE_RGBA = 2'd1;
  localparam logic [1:0] MODE_PAL  = 2'd2;

  localparam logic [2:0] FILT_NONE  = 3'd0;
  localparam logic [2:0] FILT_SUB   = 3'd1;
  localparam logic [2:0] FILT_UP    = 3'd2;
  localparam logic [2:0] FILT_AVG   = 3'd3;
  localparam logic [2:0] FILT_PAETH = 3'd4;

  localparam logic [1:0] STAT_PIXEL      = 2'd0;
  localparam logic [1:0] STAT_BAD_FILTER = 2'd1;
  localparam logic [1:0] STAT_BAD_INDEX  = 2'd2;

  localparam logic REQ_STREAM  = 1'b0;
  localparam logic REQ_PALETTE = 1'b1;

  typedef struct packed {
    logic       req;
    logic [7:0] x;
    logic [7:0] e_idx;
    logic [7:0] e_red;
    logic [7:0] e_green;
    logic [7:0] e_blue;
    logic [7:0] e_alpha;
    logic       filt_byte;
    logic [1:0] ch;
    logic       last_ch;
    logic       pal;
    logic       rgba;
    logic       row_end;
    logic       img_end;
    logic       first_row;
  } psu_item_t;

endpackage

// ===== hw/rtl/psu_predict.sv =====
// ----------------------------------------------------------------------------
// psu_predict: PNG filter reconstruction for one sample byte
// Adds the predictor chosen by the row filter (Sub, Up, Average, Paeth) to
// the filtered byte; unknown filter codes pass the byte through.
// ----------------------------------------------------------------------------
module psu_predict
  import psu_pkg::*;
(
  input  logic [2:0] filt,
  input  logic [7:0] raw,
  input  logic [7:0] left,
  input  logic [7:0] up,
  input  logic [7:0] up_left,
  output logic [7:0] result
);

  logic signed [9:0] d_bc;
  logic signed [9:0] d_ac;
  logic signed [9:0] d_sum;
  logic        [9:0] pa;
  logic        [9:0] pb;
  logic        [9:0] pc;
  logic        [7:0] paeth;
  logic        [8:0] avg_sum;

  // With p = a + b - c the three distances reduce to |b-c|, |a-c| and |a+b-2c|.
  always_comb begin
    d_bc  = $signed({2'b00, up}) - $signed({2'b00, up_left});
    d_ac  = $signed({2'b00, left}) - $signed({2'b00, up_left});
    d_sum = d_bc + d_ac;
    pa    = d_bc[9] ? 10'(-d_bc) : 10'(d_bc);
    pb    = d_ac[9] ? 10'(-d_ac) : 10'(d_ac);
    pc    = d_sum[9] ? 10'(-d_sum) : 10'(d_sum);
    if (pa <= pb && pa <= pc) begin
      paeth = left;
    end else if (pb <= pc) begin
      paeth = up;
    end else begin
      paeth = up_left;
    end
    avg_sum = {1'b0, left} + {1'b0, up};
  end

  always_comb begin
    unique case (filt)
      FILT_SUB:   result = raw + left;
      FILT_UP:    result = raw + up;
      FILT_AVG:   result = raw + avg_sum[8:1];
      FILT_PAETH: result = raw + paeth;
      default:    result = raw;
    endcase
  end

endmodule

// ===== hw/rtl/png_scanline_unfilter.sv =====
// ----------------------------------------------------------------------------
// png_scanline_unfilter: 8-bit PNG scanline unfilter with RGBA output
// Undoes the per-row filters of an inflated byte stream using a stored
// previous row and emits one RGBA word per pixel, expanding palette indices.
//
//   Channel  Dir  Word                                   Accepted when
//   s_*      in   stream byte or palette entry write     s_tvalid & s_tready
//   m_*      out  RGBA pixel or error status             m_tvalid & m_tready
//   APB      in   four configuration registers           psel&penable&pwrite
//
// One word is taken per cycle while m_tready does not stall the output. On accept
// the word is registered and the previous row memory is read; the next stage
// applies the filter, and the output register loads with the palette memory read.
// An m_tready stall holds the output; with v1 set, s_tready drops in the same cycle.
// Reset is synchronous; the row and palette memories are not cleared.
// ----------------------------------------------------------------------------
module png_scanline_unfilter
  import psu_pkg::*;
#(
  parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] stream_byte, [15:8] entry_index, [23:16] entry_red,
  // [31:24] entry_green, [39:32] entry_blue, [47:40] entry_alpha
  input  logic [47:0] s_tdata,
  // [0] req_type
  input  logic [0:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
  output logic [31:0] m_tdata,
  output logic        m_tlast,
  // [0] image_end, [2:1] status
  output logic [2:0]  m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ROW_BYTES = MAX_WIDTH * 4;
  localparam int ADDR_W    = $clog2(ROW_BYTES);
  localparam int COL_W     = $clog2(ROW_BYTES + 1);
  localparam int PAL_AW    = $clog2(PALETTE_DEPTH);

  // Configuration registers
  logic [13:0] image_width;
  logic [13:0] image_height;
  logic [1:0]  color_mode;
  logic [8:0]  palette_size;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 14'd1;
      image_height <= 14'd1;
      color_mode   <= MODE_RGBA;
      palette_size <= 9'd256;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_WIDTH:   image_width  <= pwdata[13:0];
        REG_HEIGHT:  image_height <= pwdata[13:0];
        REG_MODE:    color_mode   <= pwdata[1:0];
        REG_PALSIZE: palette_size <= pwdata[8:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:   prdata = {18'd0, image_width};
      REG_HEIGHT:  prdata = {18'd0, image_height};
      REG_MODE:    prdata = {30'd0, color_mode};
      REG_PALSIZE: prdata = {23'd0, palette_size};
      default:     prdata = 32'd0;
    endcase
  end

  // Row geometry
  logic [13:0]      width_c;
  logic [13:0]      height_c;
  logic [COL_W-1:0] w_col;
  logic [COL_W-1:0] row_len;

  always_comb begin
    if (image_width == 14'd0) begin
      width_c = 14'd1;
    end else if ({1'b0, image_width} > 15'(MAX_WIDTH)) begin
      width_c = 14'(MAX_WIDTH);
    end else begin
      width_c = image_width;
    end
    if (image_height == 14'd0) begin
      height_c = 14'd1;
    end else if ({1'b0, image_height} > 15'(MAX_HEIGHT)) begin
      height_c = 14'(MAX_HEIGHT);
    end else begin
      height_c = image_height;
    end
    w_col = COL_W'(width_c);
    case (color_mode)
      MODE_RGBA: row_len = w_col << 2;
      MODE_PAL:  row_len = w_col;
      default:   row_len = (w_col << 1) + w_col;
    endcase
  end

  // Handshake
  logic v1;
  logic v2;
  logic adv2;
  logic s1_go;
  logic s_acc;

  assign adv2     = !v2 || m_tready;
  assign s1_go    = v1 && adv2;
  assign s_tready = !v1 || adv2;
  assign s_acc    = s_tvalid && s_tready;
  assign m_tvalid = v2;

  // Input stage: position counters and previous-row read
  logic [COL_W-1:0]  col;
  logic [COL_W-1:0]  col_m1;
  logic [12:0]       row_idx;
  logic [1:0]        mod3;
  logic [ADDR_W-1:0] rd_addr;
  logic              in_filt;
  logic              in_last_col;
  logic              in_last_row;
  psu_item_t         item_in;

  always_comb begin
    col_m1      = col - COL_W'(1);
    rd_addr     = col_m1[ADDR_W-1:0];
    in_filt     = (col == '0);
    in_last_col = !in_filt && (col >= row_len);
    in_last_row = (14'(row_idx) + 14'd1) >= height_c;

    item_in.req       = s_tuser[0];
    item_in.x         = s_tdata[7:0];
    item_in.e_idx     = s_tdata[15:8];
    item_in.e_red     = s_tdata[23:16];
    item_in.e_green   = s_tdata[31:24];
    item_in.e_blue    = s_tdata[39:32];
    item_in.e_alpha   = s_tdata[47:40];
    item_in.filt_byte = in_filt;
    item_in.pal       = (color_mode == MODE_PAL);
    item_in.rgba      = (color_mode == MODE_RGBA);
    item_in.row_end   = in_last_col;
    item_in.img_end   = in_last_col && in_last_row;
    item_in.first_row = (row_idx == 13'd0);
    case (color_mode)
      MODE_RGBA: begin
        item_in.ch      = rd_addr[1:0];
        item_in.last_ch = (rd_addr[1:0] == 2'd3);
      end
      MODE_PAL: begin
        item_in.ch      = 2'd0;
        item_in.last_ch = 1'b1;
      end
      default: begin
        item_in.ch      = mod3;
        item_in.last_ch = (mod3 == 2'd2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col     <= '0;
      row_idx <= 13'd0;
      mod3    <= 2'd0;
    end else if (s_acc && s_tuser[0] == REQ_STREAM) begin
      if (in_filt) begin
        col  <= COL_W'(1);
        mod3 <= 2'd0;
      end else begin
        mod3 <= (mod3 == 2'd2) ? 2'd0 : mod3 + 2'd1;
        if (in_last_col) begin
          col     <= '0;
          row_idx <= in_last_row ? 13'd0 : row_idx + 13'd1;
        end else begin
          col <= col + COL_W'(1);
        end
      end
    end
  end

  psu_item_t         it;
  logic [ADDR_W-1:0] s1_addr;
  logic [7:0]        prior_q;
  logic [7:0]        prior_mem [ROW_BYTES];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      it      <= item_in;
      s1_addr <= rd_addr;
    end
  end

  // Unfilter stage state
  logic [2:0]  row_filter;
  logic [31:0] left_b;
  logic [31:0] upper_b;
  logic [23:0] pix;
  logic        drop;
  logic [2:0]  row_filter_next;
  logic [31:0] left_b_next;
  logic [31:0] upper_b_next;
  logic [23:0] pix_next;
  logic        drop_next;

  logic [7:0]  a_byte;
  logic [7:0]  b_byte;
  logic [7:0]  c_byte;
  logic [7:0]  xo;
  logic        mem_we;
  logic        pal_we;
  logic        pal_re;
  logic        res_valid;
  logic        res_pal;
  logic [31:0] res_rgba;
  logic        res_row_end;
  logic        res_img_end;
  logic [1:0]  res_status;

  assign a_byte = 8'(left_b >> {it.ch, 3'b000});
  assign c_byte = 8'(upper_b >> {it.ch, 3'b000});
  assign b_byte = it.first_row ? 8'd0 : prior_q;

  psu_predict u_predict (
    .filt    (row_filter),
    .raw     (it.x),
    .left    (a_byte),
    .up      (b_byte),
    .up_left (c_byte),
    .result  (xo)
  );

  always_comb begin
    row_filter_next = row_filter;
    left_b_next     = left_b;
    upper_b_next    = upper_b;
    pix_next        = pix;
    drop_next       = drop;
    mem_we          = 1'b0;
    pal_we          = 1'b0;
    pal_re          = 1'b0;
    res_valid       = 1'b0;
    res_pal         = 1'b0;
    res_rgba        = 32'd0;
    res_row_end     = 1'b0;
    res_img_end     = 1'b0;
    res_status      = STAT_PIXEL;

    if (it.req == REQ_PALETTE) begin
      pal_we = ({1'b0, it.e_idx} < 9'(PALETTE_DEPTH));
    end else if (it.filt_byte) begin
      row_filter_next = it.x[2:0];
      left_b_next     = 32'd0;
      upper_b_next    = 32'd0;
      pix_next        = 24'd0;
      if (!drop && it.x > 8'd4) begin
        drop_next  = 1'b1;
        res_valid  = 1'b1;
        res_status = STAT_BAD_FILTER;
      end
    end else begin
      if (!drop) begin
        mem_we = 1'b1;
        for (int k = 0; k < 4; k++) begin
          if (it.ch == 2'(k)) begin
            left_b_next[8*k +: 8]  = xo;
            upper_b_next[8*k +: 8] = b_byte;
          end
        end
        for (int k = 0; k < 3; k++) begin
          if (it.ch == 2'(k)) begin
            pix_next[8*k +: 8] = xo;
          end
        end
        if (it.last_ch) begin
          res_valid   = 1'b1;
          res_row_end = it.row_end;
          res_img_end = it.img_end;
          if (it.pal) begin
            if ({1'b0, xo} >= palette_size || {1'b0, xo} >= 9'(PALETTE_DEPTH)) begin
              drop_next   = 1'b1;
              res_status  = STAT_BAD_INDEX;
              res_row_end = 1'b0;
              res_img_end = 1'b0;
            end else begin
              pal_re  = 1'b1;
              res_pal = 1'b1;
            end
          end else begin
            res_rgba = {it.rgba ? xo : 8'hFF, pix_next};
          end
        end
      end
      // The end of the image always re-arms, even straight after an error.
      if (it.img_end) begin
        drop_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_filter <= FILT_NONE;
      left_b     <= 32'd0;
      upper_b    <= 32'd0;
      pix        <= 24'd0;
      drop       <= 1'b0;
    end else if (s1_go) begin
      row_filter <= row_filter_next;
      left_b     <= left_b_next;
      upper_b    <= upper_b_next;
      pix        <= pix_next;
      drop       <= drop_next;
    end
  end

  // Previous-row memory: written as a byte leaves the unfilter stage, read on accept.
  always_ff @(posedge clk) begin
    if (s1_go && mem_we) begin
      prior_mem[s1_addr] <= xo;
    end
    if (s_acc) begin
      prior_q <= prior_mem[rd_addr];
    end
  end

  // Palette memory
  logic [31:0] pal_mem [PALETTE_DEPTH];
  logic [31:0] pal_q;

  always_ff @(posedge clk) begin
    if (s1_go && pal_we) begin
      pal_mem[it.e_idx[PAL_AW-1:0]] <= {it.e_alpha, it.e_blue, it.e_green, it.e_red};
    end
    if (s1_go && pal_re) begin
      pal_q <= pal_mem[xo[PAL_AW-1:0]];
    end
  end

  // Output register
  logic [31:0] o_rgba;
  logic        o_pal;
  logic        o_row_end;
  logic        o_img_end;
  logic [1:0]  o_status;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv2) begin
      v2 <= s1_go && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      o_rgba    <= res_rgba;
      o_pal     <= res_pal;
      o_row_end <= res_row_end;
      o_img_end <= res_img_end;
      o_status  <= res_status;
    end
  end

  assign m_tdata = o_pal ? pal_q : o_rgba;
  assign m_tlast = o_row_end;
  assign m_tuser = {o_status, o_img_end};

`ifndef NO_ASSERTIONS
  a_no_row_collision: assert property (@(posedge clk) disable iff (rst)
    (s1_go && mem_we && s_acc && s_tuser[0] == REQ_STREAM && col != '0)
      |-> (s1_addr != rd_addr))
    else $error("previous-row write and read collide on one address");

  a_error_empty: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2:1] != STAT_PIXEL)
      |-> (m_tdata == 32'd0 && !m_tlast && !m_tuser[0]))
    else $error("error word carries pixel data or end marks");

  a_image_end_row_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("image end without row end");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output word present straight after reset");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for png_scanline_unfilter
// Streams whole images of filtered bytes and palette entry writes into the
// block. A behavioural unfilter in the bench predicts every pixel and error
// word, and a monitor compares each output word with the oldest prediction.
// Both stream sides idle at random, and once the output side holds off long
// enough for the input to stall.
// ----------------------------------------------------------------------------
module testbench;
  import psu_pkg::*;

  localparam int          ROW_SPAN    = MAX_WIDTH_DEF * 4;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int          RANDOM_WORDS = 1150;
  // Colour mode 3 has no name in the package; the block treats it as RGB.
  localparam logic [1:0]  MODE_RGB_ALIAS = 2'd3;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       row_end;
    logic       image_end;
    logic [1:0] status;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        m_tlast;
  logic [2:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  png_scanline_unfilter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Predicted block state and configuration.
  logic [13:0] cfg_width   = 14'd1;
  logic [13:0] cfg_height  = 14'd1;
  logic [1:0]  cfg_mode    = MODE_RGBA;
  logic [8:0]  cfg_palsize = 9'd256;
  logic [7:0]  row_mem [0:ROW_SPAN-1];
  logic [31:0] pal_mem [0:PALETTE_DEPTH_DEF-1];
  logic [31:0] left_w = '0;
  logic [31:0] upleft_w = '0;
  logic [23:0] collect = '0;
  logic [2:0]  cur_filter = FILT_NONE;
  int unsigned col = 0;
  int unsigned row = 0;
  bit          dropping = 1'b0;

  pixel_t      pending_pixels [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned words_sent = 0;
  int unsigned images_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned errors_checked = 0;

  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int unsigned tx_calm = 0;
  int unsigned rx_hold_cycles = 0;
  int unsigned pal_write_pct = 0;

  function automatic void flag_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endfunction

  function automatic int unsigned bytes_per_pixel();
    case (cfg_mode)
      MODE_RGBA: return 4;
      MODE_PAL:  return 1;
      default:   return 3;
    endcase
  endfunction

  function automatic int unsigned eff_width();
    if (cfg_width == 0) return 1;
    return (cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : cfg_width;
  endfunction

  function automatic int unsigned eff_height();
    if (cfg_height == 0) return 1;
    return (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
  endfunction

  function automatic logic [7:0] paeth_choice(input logic [7:0] a, b, c);
    int p, pa, pb, pc;
    p  = int'(a) + int'(b) - int'(c);
    pa = (p > int'(a)) ? p - int'(a) : int'(a) - p;
    pb = (p > int'(b)) ? p - int'(b) : int'(b) - p;
    pc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
    if (pa <= pb && pa <= pc) return a;
    return (pb <= pc) ? b : c;
  endfunction

  // Predictor term for the next sample byte, also used to filter random rows.
  // While a dropped image runs on, the row above is never read.
  function automatic logic [7:0] filter_guess(output logic [7:0] above);
    int unsigned i, ch;
    logic [7:0] a, c;
    logic [8:0] sum;
    i     = col - 1;
    ch    = i % bytes_per_pixel();
    above = (row == 0 || dropping) ? 8'h00 : row_mem[i % ROW_SPAN];
    a     = left_w[ch*8 +: 8];
    c     = upleft_w[ch*8 +: 8];
    sum   = a + above;
    case (cur_filter)
      FILT_SUB:   return a;
      FILT_UP:    return above;
      FILT_AVG:   return sum[8:1];
      FILT_PAETH: return paeth_choice(a, above, c);
      default:    return 8'h00;
    endcase
  endfunction

  task automatic unfilter_step(input logic req, input logic [47:0] data,
                               output bit got, output pixel_t px);
    logic [7:0]  x, above;
    int unsigned bpp, len, i, ch;
    bit          last_in_row, last_row;
    got = 1'b0;
    px  = '0;
    if (req == REQ_PALETTE) begin
      pal_mem[data[15:8]] = data[47:16];
      return;
    end
    x = data[7:0];
    if (col == 0) begin
      cur_filter = x[2:0];
      left_w     = '0;
      upleft_w   = '0;
      collect    = '0;
      col        = 1;
      if (!dropping && x > 8'(FILT_PAETH)) begin
        dropping  = 1'b1;
        px.status = STAT_BAD_FILTER;
        got       = 1'b1;
      end
      return;
    end
    bpp         = bytes_per_pixel();
    len         = eff_width() * bpp;
    i           = col - 1;
    ch          = i % bpp;
    last_in_row = (i + 1 >= len);
    last_row    = (row + 1 >= eff_height());
    if (!dropping) begin
      x = x + filter_guess(above);
      left_w[ch*8 +: 8]   = x;
      upleft_w[ch*8 +: 8] = above;
      row_mem[i % ROW_SPAN] = x;
      if (ch < 3) collect[ch*8 +: 8] = x;
      if (ch == bpp - 1) begin
        got = 1'b1;
        if (bpp == 1 && (x >= cfg_palsize || x >= PALETTE_DEPTH_DEF)) begin
          dropping  = 1'b1;
          px.status = STAT_BAD_INDEX;
        end else begin
          if (bpp == 1) begin
            {px.alpha, px.blue, px.green, px.red} = pal_mem[x];
          end else begin
            {px.blue, px.green, px.red} = collect;
            px.alpha = (bpp == 4) ? x : 8'hFF;
          end
          px.row_end   = last_in_row;
          px.image_end = last_in_row && last_row;
          px.status    = STAT_PIXEL;
        end
      end
    end
    if (last_in_row) begin
      col = 0;
      if (last_row) begin
        row      = 0;
        dropping = 1'b0;
      end else begin
        row = (row + 1) & 32'h1FFF;
      end
    end else begin
      col = (col + 1) & 32'hFFFF;
    end
  endtask

  // Offers one word, waits for the handshake and records what it must cause.
  task automatic push_word(input logic req, input logic [47:0] data);
    bit          got;
    pixel_t      px;
    int unsigned gap;
    if (tx_idle_on) begin
      if (tx_calm > 0) begin
        tx_calm--;
      end else begin
        case ($urandom_range(0, 11))
          0: begin
            gap = $urandom_range(1, 18);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          1: tx_calm = $urandom_range(20, 80);
          default: ;
        endcase
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= data;
    s_tuser  <= req;
    do @(posedge clk); while (!s_tready);
    unfilter_step(req, data, got, px);
    if (got) pending_pixels.push_back(px);
    words_sent++;
  endtask

  // Stream byte with unused entry fields filled with junk.
  task automatic push_stream(input logic [7:0] b);
    push_word(REQ_STREAM, {32'($urandom), 8'($urandom_range(0, 255)), b});
  endtask

  task automatic push_entry(input logic [7:0] idx, input logic [31:0] rgba);
    push_word(REQ_PALETTE, {rgba, idx, 8'($urandom_range(0, 255))});
  endtask

  task automatic scatter_palette_write();
    if ($urandom_range(0, 99) < pal_write_pct)
      push_entry(8'($urandom_range(0, 255)), 32'($urandom));
  endtask

  function automatic logic [7:0] pick_sample();
    int unsigned limit;
    limit = (cfg_palsize > PALETTE_DEPTH_DEF) ? PALETTE_DEPTH_DEF : cfg_palsize;
    if (cfg_mode != MODE_PAL || limit == 0 || $urandom_range(0, 99) < 5)
      return 8'($urandom_range(0, 255));
    return 8'($urandom_range(0, limit - 1));
  endfunction

  // One whole image at the current format; raw samples are filtered forward
  // so that most rows decode to chosen values.
  task automatic send_image(input int unsigned filt_noise, input int unsigned byte_noise);
    int unsigned rows, len, r, k;
    logic [7:0]  above, fb;
    rows = eff_height();
    len  = eff_width() * bytes_per_pixel();
    for (r = 0; r < rows; r++) begin
      scatter_palette_write();
      if ($urandom_range(0, 99) < filt_noise)
        fb = 8'($urandom_range(0, 255));
      else
        fb = {5'd0, 3'($urandom_range(FILT_NONE, FILT_PAETH))};
      push_stream(fb);
      for (k = 0; k < len; k++) begin
        scatter_palette_write();
        if ($urandom_range(0, 99) < byte_noise)
          push_stream(8'($urandom_range(0, 255)));
        else
          push_stream(pick_sample() - filter_guess(above));
      end
    end
    images_sent++;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    // Palette writes and dropped bytes leave no word to wait for.
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] mask;
    case (idx) inside
      REG_WIDTH, REG_HEIGHT: mask = 32'h3FFF;
      REG_MODE:              mask = 32'h3;
      default:               mask = 32'h1FF;
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_WIDTH:  cfg_width   = value[13:0];
      REG_HEIGHT: cfg_height  = value[13:0];
      REG_MODE:   cfg_mode    = value[1:0];
      default:    cfg_palsize = value[8:0];
    endcase
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== (value & mask))
      flag_failure($sformatf("register %0d read %h, expected %h", idx, prdata, value & mask));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_format(input int unsigned w, input int unsigned h,
                            input logic [1:0] mode, input int unsigned palsize);
    wait_idle();
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_PALSIZE, palsize);
  endtask

  task automatic load_palette();
    int unsigned k;
    push_entry(8'h00, 32'h0000_0000);
    for (k = 1; k < PALETTE_DEPTH_DEF - 1; k++) push_entry(8'(k), 32'($urandom));
    push_entry(8'hFF, 32'hFFFF_FFFF);
  endtask

  // Each row uses the next filter type, with samples at the extremes.
  task automatic test_filter_types();
    set_format(3, 5, MODE_PAL, 256);
    push_stream({5'd0, FILT_NONE});  push_stream(8'hFF); push_stream(8'h00); push_stream(8'h80);
    push_stream({5'd0, FILT_SUB});   push_stream(8'h01); push_stream(8'hFF); push_stream(8'h7F);
    push_stream({5'd0, FILT_UP});    push_stream(8'h00); push_stream(8'hFF); push_stream(8'h01);
    push_stream({5'd0, FILT_AVG});   push_stream(8'h80); push_stream(8'h80); push_stream(8'hFF);
    push_stream({5'd0, FILT_PAETH}); push_stream(8'hFF); push_stream(8'h01); push_stream(8'h00);
  endtask

  // Sends bad filter codes; mode 3 acts as RGB, zero width or height count as one.
  task automatic test_bad_filter();
    set_format(0, 2, MODE_RGB_ALIAS, 256);
    push_stream({5'd0, FILT_NONE}); push_stream(8'hFF); push_stream(8'h00); push_stream(8'h80);
    push_stream(8'h05); push_stream(8'h11); push_stream(8'h22); push_stream(8'h33);
    set_format(1, 0, MODE_RGB, 256);
    push_stream(8'hFF); push_stream(8'h01); push_stream(8'h02); push_stream(8'h03);
  endtask

  task automatic test_bad_index();
    set_format(1, 1, MODE_PAL, 0);
    push_stream({5'd0, FILT_NONE}); push_stream(8'h00);
    set_format(2, 1, MODE_PAL, 4);
    push_stream({5'd0, FILT_NONE}); push_stream(8'h03); push_stream(8'h04);
  endtask

  // The output side refuses words long enough for the input side to stall.
  task automatic test_backpressure();
    set_format(4, 3, MODE_RGBA, 256);
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 300;
    send_image(0, 0);
    send_image(0, 0);
  endtask

  // Register values beyond the legal range read back as written, and small
  // images check zero sizes and palette counts of zero or beyond the table.
  task automatic test_size_limits();
    tx_idle_on    = 1'b0;
    rx_idle_on    = 1'b0;
    pal_write_pct = 0;
    set_format(16383, 16383, MODE_RGB_ALIAS, 511);
    set_format(0, 0, MODE_PAL, 511);
    send_image(0, 0);
    set_format(3, 0, MODE_PAL, 0);
    send_image(0, 0);
    set_format(6, 3, MODE_PAL, 300);
    send_image(0, 0);
    set_format(5, 2, MODE_RGB, 256);
    send_image(4, 0);
  endtask

  task automatic test_random_images();
    int unsigned start, w, h, palsize, n, k;
    start         = words_sent;
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    pal_write_pct = 4;
    while (words_sent - start < RANDOM_WORDS) begin
      // The last quarter runs with both sides flowing freely.
      if (words_sent - start > RANDOM_WORDS * 3 / 4) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      case ($urandom_range(0, 9))
        0:       w = $urandom_range(9, 40);
        1:       w = 0;
        default: w = $urandom_range(1, 8);
      endcase
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
      case ($urandom_range(0, 9))
        0:       palsize = 0;
        1:       palsize = $urandom_range(257, 511);
        2, 3:    palsize = PALETTE_DEPTH_DEF;
        default: palsize = $urandom_range(1, 255);
      endcase
      set_format(w, h, 2'($urandom_range(0, 3)), palsize);
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) send_image(6, 3);
    end
  endtask

  // Output side: random refusal bursts, calm stretches, and long holds on request.
  initial begin : rx_side
    int unsigned n;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        n = rx_hold_cycles;
        rx_hold_cycles = 0;
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 11) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        m_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 15) == 0) begin
        m_tready <= 1'b1;
        repeat ($urandom_range(20, 80)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_pixels.size() == 0) begin
        flag_failure($sformatf("unexpected word data %h last %b user %b",
                               m_tdata, m_tlast, m_tuser));
      end else begin
        want = pending_pixels.pop_front();
        if (want.status == STAT_PIXEL) pixels_checked++;
        else errors_checked++;
        if (m_tdata[7:0] !== want.red || m_tdata[15:8] !== want.green ||
            m_tdata[23:16] !== want.blue || m_tdata[31:24] !== want.alpha ||
            m_tlast !== want.row_end || m_tuser[0] !== want.image_end ||
            m_tuser[2:1] !== want.status)
          flag_failure($sformatf(
            "rgba %h %h %h %h row_end %b image_end %b status %0d, got %h %h %h %h %b %b %0d",
            want.red, want.green, want.blue, want.alpha, want.row_end, want.image_end,
            want.status, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[31:24],
            m_tlast, m_tuser[0], m_tuser[2:1]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding.",
               cycle_count, pending_pixels.size());
      $display("testbench NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    load_palette();
    test_filter_types();
    test_bad_filter();
    test_bad_index();
    test_backpressure();
    test_size_limits();
    test_random_images();
    wait_idle();
    repeat (20) @(posedge clk);
    $display("Sent %0d input words across %0d generated images plus directed rows.",
             words_sent, images_sent);
    $display("Checked %0d pixel words and %0d error words; %0d failures.",
             pixels_checked, errors_checked, fail_count);
    if (fail_count == 0 && pending_pixels.size() == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
